FILE: hw/rtl/wsld_pkg.sv
package wsld_pkg;

	localparam int DATA_W = 32;
	localparam int NUM_AXES = 3;
	localparam int WINDOW_DEPTH_DEF = 16;
	localparam logic [DATA_W-1:0] THRESHOLD_RESET = 32'd655;

	typedef struct packed {
		logic start;
		logic rd_en;
	} scan_ctl_t;

	typedef struct packed {
		logic [DATA_W-1:0] hi;
		logic [DATA_W-1:0] lo;
	} axis_span_t;

endpackage

FILE: hw/rtl/window_stability_lock_detector.sv
// Channel  | Handshake                 | Payload
// ---------+---------------------------+---------------------------------------------
// input    | in_valid / in_stall       | restart, var_x, var_y, var_z, positioning_ok,
//          |                           | calibrated
// output   | out_valid / out_stall     | locked
// config   | cfg_valid / cfg_ready     | cfg_data (spread threshold)
//
// A sample item over a full window steps through one write, WINDOW_DEPTH reads of the
// per-axis window RAMs, one drain and one merge. Restart items and items over a
// window not yet full skip the reads and the drain.
// One item in flight; a new item is taken while the previous result waits in the
// output register. Reset clears window pointers and fill count, sets threshold 655.
// A stalled output holds the merge state until the output register frees up.
module window_stability_lock_detector #(
	parameter int WINDOW_DEPTH = wsld_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        restart,
	input  logic [wsld_pkg::DATA_W-1:0] var_x,
	input  logic [wsld_pkg::DATA_W-1:0] var_y,
	input  logic [wsld_pkg::DATA_W-1:0] var_z,
	input  logic                        positioning_ok,
	input  logic                        calibrated,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        locked,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [wsld_pkg::DATA_W-1:0] cfg_data
);

	localparam int ADDR_W = $clog2(WINDOW_DEPTH);
	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_MERGE = 2'd3;

	logic [1:0]                  state_q;
	logic [ADDR_W-1:0]           write_slot_q;
	logic [FILL_W-1:0]           fill_q;
	logic [ADDR_W-1:0]           scan_idx_q;
	logic                        eval_q;
	logic                        flags_q;
	logic [wsld_pkg::DATA_W-1:0] threshold_q;
	logic                        out_valid_q;
	logic                        locked_q;

	logic                        in_accept;
	logic                        sample_wr;
	logic                        full_next;
	logic                        out_free;
	logic                        merge_locked;
	wsld_pkg::scan_ctl_t         scan_ctl;
	wsld_pkg::axis_span_t        spans [wsld_pkg::NUM_AXES];
	logic [wsld_pkg::DATA_W-1:0] var_in [wsld_pkg::NUM_AXES];

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign sample_wr = in_accept && !restart;
	assign full_next = (fill_q == FILL_W'(WINDOW_DEPTH)) ||
	                   (fill_q == FILL_W'(WINDOW_DEPTH - 1));
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	assign scan_ctl.start = sample_wr;
	assign scan_ctl.rd_en = (state_q == ST_SCAN);

	assign var_in[0] = var_x;
	assign var_in[1] = var_y;
	assign var_in[2] = var_z;

	for (genvar a = 0; a < wsld_pkg::NUM_AXES; a++) begin : g_lane
		wsld_lane #(
			.WINDOW_DEPTH(WINDOW_DEPTH)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (sample_wr),
			.wr_addr (write_slot_q),
			.wr_data (var_in[a]),
			.ctl     (scan_ctl),
			.rd_addr (scan_idx_q),
			.span    (spans[a])
		);
	end

	wsld_merge u_merge (
		.spans     (spans),
		.threshold (threshold_q),
		.eval      (eval_q),
		.flags_ok  (flags_q),
		.locked    (merge_locked)
	);

	always_ff @(posedge clk) begin
		if (sample_wr) begin
			flags_q <= positioning_ok && calibrated;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= wsld_pkg::THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			threshold_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			write_slot_q <= '0;
			fill_q       <= '0;
			scan_idx_q   <= '0;
			eval_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			locked_q     <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_MERGE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						scan_idx_q <= '0;
						if (restart) begin
							write_slot_q <= '0;
							fill_q       <= '0;
							eval_q       <= 1'b0;
							state_q      <= ST_MERGE;
						end else begin
							if (write_slot_q == ADDR_W'(WINDOW_DEPTH - 1)) begin
								write_slot_q <= '0;
							end else begin
								write_slot_q <= write_slot_q + 1'b1;
							end
							if (fill_q != FILL_W'(WINDOW_DEPTH)) begin
								fill_q <= fill_q + 1'b1;
							end
							eval_q  <= full_next;
							state_q <= full_next ? ST_SCAN : ST_MERGE;
						end
					end
				end
				ST_SCAN: begin
					if (scan_idx_q == ADDR_W'(WINDOW_DEPTH - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						locked_q    <= merge_locked;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign locked    = locked_q;

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> in_stall)
		else $error("input taken while an item is in flight");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW_DEPTH))
		else $error("fill count beyond window depth");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_MERGE))
		else $error("result loaded outside merge");

	a_lock_needs_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE && merge_locked) |-> eval_q && $past(state_q != ST_IDLE))
		else $error("lock reported without a window scan");

endmodule

FILE: hw/rtl/wsld_lane.sv
module wsld_lane #(
	parameter int WINDOW_DEPTH = wsld_pkg::WINDOW_DEPTH_DEF,
	localparam int ADDR_W = $clog2(WINDOW_DEPTH)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [ADDR_W-1:0]           wr_addr,
	input  logic [wsld_pkg::DATA_W-1:0] wr_data,
	input  wsld_pkg::scan_ctl_t         ctl,
	input  logic [ADDR_W-1:0]           rd_addr,
	output wsld_pkg::axis_span_t        span
);

	logic [wsld_pkg::DATA_W-1:0] mem [WINDOW_DEPTH];
	logic [wsld_pkg::DATA_W-1:0] rd_data_s1;
	logic                        rd_vld_s1;
	logic [wsld_pkg::DATA_W-1:0] hi_q;
	logic [wsld_pkg::DATA_W-1:0] lo_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			hi_q      <= '0;
			lo_q      <= '1;
		end else begin
			rd_vld_s1 <= ctl.rd_en;
			if (ctl.start) begin
				hi_q <= '0;
				lo_q <= '1;
			end else if (rd_vld_s1) begin
				if (rd_data_s1 > hi_q) begin
					hi_q <= rd_data_s1;
				end
				if (rd_data_s1 < lo_q) begin
					lo_q <= rd_data_s1;
				end
			end
		end
	end

	assign span.hi = hi_q;
	assign span.lo = lo_q;

endmodule

FILE: hw/rtl/wsld_merge.sv
module wsld_merge (
	input  wsld_pkg::axis_span_t        spans [wsld_pkg::NUM_AXES],
	input  logic [wsld_pkg::DATA_W-1:0] threshold,
	input  logic                        eval,
	input  logic                        flags_ok,
	output logic                        locked
);

	logic [wsld_pkg::NUM_AXES-1:0] axis_ok;

	always_comb begin
		for (int a = 0; a < wsld_pkg::NUM_AXES; a++) begin
			axis_ok[a] = (spans[a].hi - spans[a].lo) < threshold;
		end
	end

	assign locked = eval && flags_ok && (&axis_ok);

endmodule
